/* design/pip_pkg.sv */
// shared types and constants for the point-in-polygon crossing block
// no dependencies; imported by pip_ctrl, pip_datapath, the top level and the testbench
package pip_pkg;

   localparam int RAY_WIDTH = 31;
   localparam int unsigned RAY_DEFAULT_UNITS = 1000;

   // partial products issued to the shared multiplier for one edge
   typedef enum logic [2:0] {
      STEP_XG_LO,
      STEP_XG_HI,
      STEP_XZ_LO,
      STEP_XZ_HI,
      STEP_GL_LO,
      STEP_GL_HI
   } mul_step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LOAD,
      ST_MUL,
      ST_DRAIN,
      ST_CHECK,
      ST_EMIT
   } pip_state_type;

   typedef struct packed {
      logic         ready;
      logic         take;
      logic         load;
      logic         edge_close;
      logic         mul_issue;
      mul_step_type step;
      logic         check;
      logic         emit;
   } pip_cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic out_busy;
   } pip_status_type;

endpackage

/* design/pip_ctrl.sv */
// sequencer for the point-in-polygon crossing block
// walks each edge through load, multiply passes and check; uses pip_pkg
module pip_ctrl
   import pip_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  pip_status_type status,
   output pip_cmd_type    cmd
);

   pip_state_type state_ff, state_in;
   mul_step_type  step_ff, step_in;
   logic          edge_ff, edge_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_XG_LO;
         edge_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         edge_ff  <= edge_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      edge_in  = edge_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.first) begin
               edge_in  = 1'b0;
               state_in = ST_LOAD;
            end else if (status.last) begin
               edge_in  = 1'b1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            step_in  = STEP_XG_LO;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            unique case (step_ff)
               STEP_XG_LO: step_in = STEP_XG_HI;
               STEP_XG_HI: step_in = STEP_XZ_LO;
               STEP_XZ_LO: step_in = STEP_XZ_HI;
               STEP_XZ_HI: step_in = STEP_GL_LO;
               STEP_GL_LO: step_in = STEP_GL_HI;
               STEP_GL_HI: step_in = STEP_XG_LO;
               default:    step_in = STEP_XG_LO;
            endcase
            if (step_ff == STEP_GL_HI) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_CHECK;
         ST_CHECK: begin
            if (edge_ff) begin
               state_in = ST_EMIT;
            end else if (status.last) begin
               edge_in  = 1'b1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.edge_close = edge_ff;
      cmd.step       = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            cmd.take  = req_tvalid;
         end
         ST_LOAD:  cmd.load = 1'b1;
         ST_MUL:   cmd.mul_issue = 1'b1;
         ST_CHECK: cmd.check = 1'b1;
         ST_EMIT:  cmd.emit = !status.out_busy;
         ST_DECIDE, ST_DRAIN: begin
         end
         default: begin
         end
      endcase
   end

   a_take_decide: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> state_ff == ST_DECIDE)
      else $error("accepted word not followed by decode");

   a_close_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && edge_ff) |-> status.last)
      else $error("closing edge on a non-last vertex");

   a_close_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && edge_ff) |=> state_ff == ST_EMIT)
      else $error("closing edge check not followed by emit");

   a_mul_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && step_ff == STEP_GL_HI) |=> state_ff == ST_DRAIN)
      else $error("multiply sequence did not end in drain");

endmodule

/* design/pip_datapath.sv */
// datapath: held vertices, edge differences, shared half-width multiplier,
// accumulators, parity and result register; uses pip_pkg, driven by pip_ctrl
module pip_datapath
   import pip_pkg::*;
#(
   parameter int                   CW        = 32,
   parameter logic [RAY_WIDTH-1:0] RAY_RESET = 31'd65536000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pip_cmd_type          cmd,
   output pip_status_type       status,
   input  logic signed [CW-1:0] in_point_x,
   input  logic signed [CW-1:0] in_point_z,
   input  logic signed [CW-1:0] in_vertex_x,
   input  logic signed [CW-1:0] in_vertex_z,
   input  logic                 in_first,
   input  logic                 in_last,
   input  logic                 csr_valid,
   input  logic [RAY_WIDTH-1:0] csr_data,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output logic                 inside_res
);

   localparam int DW1 = CW + 1;
   localparam int OW  = (DW1 > RAY_WIDTH + 1) ? DW1 : RAY_WIDTH + 1;
   localparam int MW  = (OW + 1) / 2;
   localparam int PW  = OW + MW + 1;
   localparam int AW  = 2 * OW + 2;

   // item and polygon state
   logic signed [CW-1:0] pt_x_ff, pt_x_in, pt_z_ff, pt_z_in;
   logic signed [CW-1:0] vt_x_ff, vt_x_in, vt_z_ff, vt_z_in;
   logic signed [CW-1:0] start_x_ff, start_x_in, start_z_ff, start_z_in;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_z_ff, prev_z_in;
   logic                 first_ff, first_in, last_ff, last_in;
   logic                 parity_ff, parity_in;
   logic [RAY_WIDTH-1:0] ray_ff, ray_in;
   logic                 rsp_valid_ff, rsp_valid_in, inside_ff, inside_in;

   // edge terms, sign normalized so the z step is never negative
   logic signed [CW:0]   g0_ff, g0_in, g2n_ff, g2n_in, x0_ff, x0_in, x2n_ff, x2n_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   mul_step_type         tag_ff, tag_in;
   logic                 pv_ff, pv_in;
   logic signed [AW-1:0] acc_n_ff, acc_n_in, acc_l_ff, acc_l_in;

   logic signed [CW-1:0] ax, az, bx, bz;
   logic signed [CW:0]   dz_pos, dz_neg, cz_pos, cz_neg, dx0, dx_g;
   logic signed [OW-1:0] a_op, b_op;
   logic signed [MW:0]   b_chunk;
   logic                 use_hi, tag_hi, tag_sub, tag_l;
   logic signed [AW-1:0] pext, addend;
   logic                 x2_ok, n_ok, toggle;

   always_comb begin
      ax = cmd.edge_close ? vt_x_ff : prev_x_ff;
      az = cmd.edge_close ? vt_z_ff : prev_z_ff;
      bx = cmd.edge_close ? start_x_ff : vt_x_ff;
      bz = cmd.edge_close ? start_z_ff : vt_z_ff;
      dx_g   = DW1'(bx) - DW1'(ax);
      dz_pos = DW1'(bz) - DW1'(az);
      dz_neg = DW1'(az) - DW1'(bz);
      cz_pos = DW1'(pt_z_ff) - DW1'(az);
      cz_neg = DW1'(az) - DW1'(pt_z_ff);
      dx0    = DW1'(pt_x_ff) - DW1'(ax);
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (cmd.step)
         STEP_XG_LO, STEP_XG_HI: begin
            a_op = OW'(x2n_ff);
            b_op = OW'(g0_ff);
         end
         STEP_XZ_LO, STEP_XZ_HI: begin
            a_op = OW'(x0_ff);
            b_op = OW'(g2n_ff);
         end
         default: begin
            a_op = OW'(g2n_ff);
            b_op = $signed(OW'(ray_ff));
         end
      endcase
      use_hi = (cmd.step == STEP_XG_HI) || (cmd.step == STEP_XZ_HI) ||
               (cmd.step == STEP_GL_HI);
      if (use_hi) b_chunk = (MW + 1)'($signed(b_op[OW-1:MW]));
      else        b_chunk = $signed({1'b0, b_op[MW-1:0]});
      prod_in = a_op * b_chunk;
   end

   // accumulate the registered partial product
   always_comb begin
      tag_hi  = (tag_ff == STEP_XG_HI) || (tag_ff == STEP_XZ_HI) || (tag_ff == STEP_GL_HI);
      tag_sub = (tag_ff == STEP_XZ_LO) || (tag_ff == STEP_XZ_HI);
      tag_l   = (tag_ff == STEP_GL_LO) || (tag_ff == STEP_GL_HI);
      pext    = AW'(prod_ff);
      addend  = tag_hi ? (pext <<< MW) : pext;
   end

   always_comb begin
      x2_ok  = !x2n_ff[CW] && (|x2n_ff) && (x2n_ff < g2n_ff);
      n_ok   = !acc_n_ff[AW-1] && (|acc_n_ff) && (acc_n_ff < acc_l_ff);
      toggle = x2_ok && n_ok;
   end

   always_comb begin
      pt_x_in      = pt_x_ff;
      pt_z_in      = pt_z_ff;
      vt_x_in      = vt_x_ff;
      vt_z_in      = vt_z_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      start_x_in   = start_x_ff;
      start_z_in   = start_z_ff;
      prev_x_in    = prev_x_ff;
      prev_z_in    = prev_z_ff;
      parity_in    = parity_ff;
      ray_in       = csr_valid ? csr_data : ray_ff;
      g0_in        = g0_ff;
      g2n_in       = g2n_ff;
      x0_in        = x0_ff;
      x2n_in       = x2n_ff;
      tag_in       = cmd.step;
      pv_in        = cmd.mul_issue;
      acc_n_in     = acc_n_ff;
      acc_l_in     = acc_l_ff;
      inside_in    = inside_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.take) begin
         pt_x_in  = in_point_x;
         pt_z_in  = in_point_z;
         vt_x_in  = in_vertex_x;
         vt_z_in  = in_vertex_z;
         first_in = in_first;
         last_in  = in_last;
         if (in_first) begin
            start_x_in = in_vertex_x;
            start_z_in = in_vertex_z;
            prev_x_in  = in_vertex_x;
            prev_z_in  = in_vertex_z;
            parity_in  = 1'b0;
         end
      end

      if (cmd.load) begin
         g0_in    = dx_g;
         x0_in    = dx0;
         g2n_in   = dz_pos[CW] ? dz_neg : dz_pos;
         x2n_in   = dz_pos[CW] ? cz_neg : cz_pos;
         acc_n_in = '0;
         acc_l_in = '0;
      end else if (pv_ff) begin
         if (tag_l)        acc_l_in = acc_l_ff + addend;
         else if (tag_sub) acc_n_in = acc_n_ff - addend;
         else              acc_n_in = acc_n_ff + addend;
      end

      if (cmd.check) begin
         if (toggle) parity_in = !parity_ff;
         if (!cmd.edge_close) begin
            prev_x_in = vt_x_ff;
            prev_z_in = vt_z_ff;
         end
      end

      if (cmd.emit) begin
         inside_in    = parity_ff;
         parity_in    = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= '0;
         start_z_ff   <= '0;
         prev_x_ff    <= '0;
         prev_z_ff    <= '0;
         parity_ff    <= 1'b0;
         ray_ff       <= RAY_RESET;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_x_ff   <= start_x_in;
         start_z_ff   <= start_z_in;
         prev_x_ff    <= prev_x_in;
         prev_z_ff    <= prev_z_in;
         parity_ff    <= parity_in;
         ray_ff       <= ray_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_x_ff   <= pt_x_in;
      pt_z_ff   <= pt_z_in;
      vt_x_ff   <= vt_x_in;
      vt_z_ff   <= vt_z_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      g0_ff     <= g0_in;
      g2n_ff    <= g2n_in;
      x0_ff     <= x0_in;
      x2n_ff    <= x2n_in;
      prod_ff   <= prod_in;
      tag_ff    <= tag_in;
      acc_n_ff  <= acc_n_in;
      acc_l_ff  <= acc_l_in;
      inside_ff <= inside_in;
   end

   always_comb begin
      status.first    = first_ff;
      status.last     = last_ff;
      status.out_busy = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign inside_res = inside_ff;

endmodule

/* design/point_in_polygon_crossing.sv */
// top level of the even-odd point-in-polygon crossing test
// joins pip_ctrl and pip_datapath; uses pip_pkg
//
//  channel | dir | handshake                | payload
//  req_    | in  | req_tvalid / req_tready  | tdata points and vertex, tuser first, tlast last
//  rsp_    | out | rsp_tvalid / rsp_tready  | tdata bit 0 inside_res
//  csr_    | in  | csr_valid / csr_ready    | csr_data ray_length
//
// an item that opens a polygon and is not last is only accepted and decoded; any other
// non-last item is accepted, decoded, loaded, taken through six passes of the shared
// half-width multiplier, drained and checked; a last item adds a closing edge with the
// same steps and an emit step; three products per edge, each in two halves, give the passes.
// reset clears the held vertices, parity and result valid flag and loads the default ray.
// a waiting result stalls only the next emit step; items before that emit are still taken.
module point_in_polygon_crossing
   import pip_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // point_x, point_z, vertex_x, vertex_z, then zero fill
   input  logic [((4 * COORD_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // first_vertex
   input  logic                                     req_tuser,
   input  logic                                     req_tlast,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // inside_res, then zero fill
   output logic [7:0]                               rsp_tdata,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [RAY_WIDTH-1:0]                     csr_data
);

   localparam int CW = COORD_WIDTH;
   localparam logic [63:0] RayFull = 64'(RAY_DEFAULT_UNITS) << FRAC_BITS;
   localparam logic [63:0] RayMax  = (64'd1 << RAY_WIDTH) - 64'd1;
   localparam logic [RAY_WIDTH-1:0] RayReset =
      (RayFull > RayMax) ? RayMax[RAY_WIDTH-1:0] : RayFull[RAY_WIDTH-1:0];

   pip_cmd_type    cmd;
   pip_status_type status;
   logic           inside_res;

   pip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   pip_datapath #(
      .CW        (CW),
      .RAY_RESET (RayReset)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_point_x  ($signed(req_tdata[CW-1:0])),
      .in_point_z  ($signed(req_tdata[2*CW-1:CW])),
      .in_vertex_x ($signed(req_tdata[3*CW-1:2*CW])),
      .in_vertex_z ($signed(req_tdata[4*CW-1:3*CW])),
      .in_first    (req_tuser),
      .in_last     (req_tlast),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .inside_res  (inside_res)
   );

   assign req_tready = cmd.ready;
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {7'b0, inside_res};

endmodule

/* verif/tb_point_in_polygon_crossing.sv */
// testbench for point_in_polygon_crossing: streams polygons and checks each inside word
// against an even-odd crossing predictor; needs pip_pkg and the design files only
module tb_point_in_polygon_crossing
   import pip_pkg::*;
;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 32;
   localparam int RANDOM_ITEMS = 1100;
   localparam int PHASES       = 8;
   localparam logic [31:0] C_MIN = 32'h8000_0000;
   localparam logic [31:0] C_MAX = 32'h7fff_ffff;
   localparam logic [RAY_WIDTH-1:0] RAY_MAX = {RAY_WIDTH{1'b1}};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [127:0]         req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [RAY_WIDTH-1:0] csr_data = '0;

   // predictor copy of the block state
   logic signed [31:0]   held_start_x, held_start_z, held_prev_x, held_prev_z;
   bit                   parity_now;
   logic [RAY_WIDTH-1:0] ray_now;
   bit                   inside_expected[$];

   int  mismatch_count = 0;
   int  sent_count = 0;
   int  cycle_count = 0;
   int  rsp_stall = 0;
   bit  steady_flow = 1'b0;

   point_in_polygon_crossing dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] q(int v);
      return v << 16;
   endfunction

   function automatic int pick_gap();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] rand_offset(int span);
      logic [31:0] r;
      if (span >= 32)
         return $urandom();
      r = $urandom() & ((32'd1 << span) - 32'd1);
      return r - (32'd1 << (span - 1));
   endfunction

   // edge a->b against the ray from c, all divisions cross-multiplied
   function automatic bit edge_crosses(logic signed [31:0] ax, az, bx, bz, cx, cz,
                                       logic [RAY_WIDTH-1:0] ray);
      logic signed [127:0] g0, g2, x0, x2, n, gl, ray_w;
      g0 = bx;
      g0 = g0 - ax;
      g2 = bz;
      g2 = g2 - az;
      x0 = cx;
      x0 = x0 - ax;
      x2 = cz;
      x2 = x2 - az;
      ray_w = {{(128 - RAY_WIDTH){1'b0}}, ray};
      if (g2 == 0)
         return 1'b0;
      n = x2 * g0 - x0 * g2;
      if (g2 < 0) begin
         g2 = -g2;
         x2 = -x2;
         n = -n;
      end
      if (!(x2 > 0 && x2 < g2))
         return 1'b0;
      gl = g2 * ray_w;
      return (n > 0) && (n < gl);
   endfunction

   task automatic predict_vertex(logic signed [31:0] px, pz, vx, vz, bit first, bit last);
      if (first) begin
         held_start_x = vx;
         held_start_z = vz;
         parity_now = 1'b0;
      end else if (edge_crosses(held_prev_x, held_prev_z, vx, vz, px, pz, ray_now)) begin
         parity_now ^= 1'b1;
      end
      held_prev_x = vx;
      held_prev_z = vz;
      if (last) begin
         if (edge_crosses(vx, vz, held_start_x, held_start_z, px, pz, ray_now))
            parity_now ^= 1'b1;
         inside_expected.push_back(parity_now);
         parity_now = 1'b0;
      end
   endtask

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic send_vertex(logic [31:0] px, pz, vx, vz, bit first, bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {vz, vx, pz, px};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_vertex(px, pz, vx, vz, first, last);
      sent_count++;
   endtask

   // sender holds off until every inside word has come back
   task automatic drain_results();
      @(negedge clock) req_tvalid <= 1'b0;
      while (inside_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_ray(logic [RAY_WIDTH-1:0] value);
      drain_results();
      // a non-last vertex may still be in flight
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      ray_now = value;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic send_random_polygon();
      logic [31:0] cx, cz, px, pz, vx, vz, last_vz;
      int  span, count, sel, i;
      bit  noisy, f, l;
      sel = $urandom_range(0, 99);
      if (sel < 15)
         count = $urandom_range(1, 2);
      else if (sel < 90)
         count = $urandom_range(3, 5);
      else
         count = $urandom_range(6, 12);
      sel = $urandom_range(0, 99);
      span = (sel < 40) ? 6 : ((sel < 80) ? 20 : 32);
      noisy = ($urandom_range(0, 9) == 0);
      cx = $urandom();
      cz = $urandom();
      px = cx + rand_offset(span);
      pz = cz + rand_offset(span);
      last_vz = cz;
      for (i = 0; i < count; i++) begin
         vx = cx + rand_offset(span);
         sel = $urandom_range(0, 99);
         // flat edges and vertices level with the ray come up often
         if (sel < 12)
            vz = last_vz;
         else if (sel < 20)
            vz = pz;
         else
            vz = cz + rand_offset(span);
         if ($urandom_range(0, 9) == 0) begin
            px = cx + rand_offset(span);
            pz = cz + rand_offset(span);
         end
         f = noisy ? bit'($urandom_range(0, 1)) : (i == 0);
         l = noisy ? ($urandom_range(0, 3) == 0) : (i == count - 1);
         send_vertex(px, pz, vx, vz, f, l);
         last_vz = vz;
      end
   endtask

   task automatic test_default_ray_shapes();
      // no first vertex after reset: closes to the cleared start
      send_vertex(q(2), q(1), q(4), q(3), 1'b0, 1'b1);
      // ten-unit square, point inside
      send_vertex(q(5), q(5), q(0), q(0), 1'b1, 1'b0);
      send_vertex(q(5), q(5), q(10), q(0), 1'b0, 1'b0);
      send_vertex(q(5), q(5), q(10), q(10), 1'b0, 1'b0);
      send_vertex(q(5), q(5), q(0), q(10), 1'b0, 1'b1);
      // same square, point moves on every vertex
      send_vertex(q(-5), q(5), q(0), q(0), 1'b1, 1'b0);
      send_vertex(q(5), q(3), q(10), q(0), 1'b0, 1'b0);
      send_vertex(q(20), q(5), q(10), q(10), 1'b0, 1'b0);
      send_vertex(q(-3), q(7), q(0), q(10), 1'b0, 1'b1);
      // one vertex only
      send_vertex(q(0), q(0), q(3), q(3), 1'b1, 1'b1);
      // point level with a vertex
      send_vertex(q(2), q(5), q(0), q(0), 1'b1, 1'b0);
      send_vertex(q(2), q(5), q(10), q(5), 1'b0, 1'b0);
      send_vertex(q(2), q(5), q(0), q(10), 1'b0, 1'b1);
      // coordinate extremes
      send_vertex(32'd0, 32'd0, C_MIN, C_MIN, 1'b1, 1'b0);
      send_vertex(32'd0, 32'd0, C_MAX, C_MIN, 1'b0, 1'b0);
      send_vertex(32'd0, 32'd0, C_MAX, C_MAX, 1'b0, 1'b1);
   endtask

   task automatic test_ray_extremes();
      write_ray('0);
      send_vertex(q(5), q(5), q(0), q(0), 1'b1, 1'b0);
      send_vertex(q(5), q(5), q(10), q(5), 1'b0, 1'b0);
      send_vertex(q(5), q(5), q(10), q(10), 1'b0, 1'b1);
      write_ray({{(RAY_WIDTH - 1){1'b0}}, 1'b1});
      send_vertex(32'd1, 32'd1, 32'd2, 32'd0, 1'b1, 1'b0);
      send_vertex(32'd1, 32'd1, 32'd2, 32'd3, 1'b0, 1'b0);
      send_vertex(32'd1, 32'd1, 32'd0, 32'd1, 1'b0, 1'b1);
      write_ray(RAY_MAX);
      send_vertex(32'h8000_0001, 32'd1, C_MIN, C_MAX, 1'b1, 1'b0);
      send_vertex(32'h8000_0001, 32'd1, C_MIN, C_MIN, 1'b0, 1'b0);
      send_vertex(32'h8000_0001, 32'd1, C_MAX, 32'd0, 1'b0, 1'b1);
   endtask

   task automatic test_random_polygons();
      int phase, phase_start, sel;
      logic [RAY_WIDTH-1:0] ray_pick;
      for (phase = 0; phase < PHASES; phase++) begin
         sel = $urandom_range(0, 3);
         if (phase == 0)
            ray_pick = RAY_MAX;
         else if (phase == 1)
            ray_pick = RAY_WIDTH'(1);
         else if (sel == 0)
            ray_pick = RAY_WIDTH'(65536000);
         else if (sel == 1)
            ray_pick = RAY_WIDTH'($urandom_range(1, 1 << 20));
         else
            ray_pick = RAY_WIDTH'($urandom());
         write_ray(ray_pick);
         steady_flow = (phase % 3 == 2);
         phase_start = sent_count;
         while (sent_count - phase_start < RANDOM_ITEMS / PHASES) begin
            send_random_polygon();
            if (phase == 3 && sent_count - phase_start > RANDOM_ITEMS / (2 * PHASES)
                && sent_count - phase_start < RANDOM_ITEMS / (2 * PHASES) + 6)
               drain_results();
         end
      end
      steady_flow = 1'b0;
   endtask

   // receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (inside_expected.size() == 0) begin
            note_mismatch($sformatf("unexpected inside word %h", rsp_tdata));
         end else if (rsp_tdata !== {7'd0, inside_expected[0]}) begin
            note_mismatch($sformatf("inside expected %h actual %h",
                                    {7'd0, inside_expected[0]}, rsp_tdata));
            void'(inside_expected.pop_front());
         end else begin
            void'(inside_expected.pop_front());
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      held_start_x = '0;
      held_start_z = '0;
      held_prev_x  = '0;
      held_prev_z  = '0;
      parity_now   = 1'b0;
      ray_now      = RAY_WIDTH'(RAY_DEFAULT_UNITS << 16);
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_default_ray_shapes();
      test_ray_extremes();
      test_random_polygons();
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && inside_expected.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
